// ----- rtl/bmsv_pkg.sv -----
// bmsv_pkg: shared types for the bitonic merge of two sorted vectors
// lane and vector types used by the merge networks and the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bmsv_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned WORDS   = 4;
  localparam int unsigned NLANE_W = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [WORDS-1:0][WORD_W-1:0] vec_t;
  typedef logic signed [NLANE_W-1:0] nlane_t;
  typedef logic signed [WORD_W-1:0] wlane_t;

  typedef enum logic {
    MODE_NARROW = 1'b0,
    MODE_WIDE   = 1'b1
  } mode_t;

endpackage

`default_nettype wire

// ----- rtl/bmsv_merge16.sv -----
// bmsv_merge16: merge network over sixteen signed 32-bit lanes
// two lanes to each word, even lane in the low half; uses bmsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module bmsv_merge16 (
  input  var bmsv_pkg::vec_t a,
  input  var bmsv_pkg::vec_t b,
  output bmsv_pkg::vec_t     lo,
  output bmsv_pkg::vec_t     hi
);

  localparam int unsigned N = 2 * bmsv_pkg::WORDS * 2;
  localparam int unsigned H = N / 2;

  bmsv_pkg::nlane_t st0 [N];
  bmsv_pkg::nlane_t st1 [N];
  bmsv_pkg::nlane_t st2 [N];
  bmsv_pkg::nlane_t st3 [N];
  bmsv_pkg::nlane_t st4 [N];

  // unpack, with the second vector reversed so the whole row is bitonic
  always_comb begin
    for (int k = 0; k < H / 2; k++) begin
      st0[2*k]         = a[k][31:0];
      st0[2*k+1]       = a[k][63:32];
      st0[N-1-2*k]     = b[k][31:0];
      st0[N-2-2*k]     = b[k][63:32];
    end
  end

  always_comb begin
    for (int i = 0; i < H; i++) begin
      st1[i]   = (st0[i] > st0[i+H]) ? st0[i+H] : st0[i];
      st1[i+H] = (st0[i] > st0[i+H]) ? st0[i] : st0[i+H];
    end
  end

  // half-cleaners at distance 4, 2 and 1
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if ((i & 4) == 0) begin
        st2[i]   = (st1[i] > st1[i+4]) ? st1[i+4] : st1[i];
        st2[i+4] = (st1[i] > st1[i+4]) ? st1[i] : st1[i+4];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if ((i & 2) == 0) begin
        st3[i]   = (st2[i] > st2[i+2]) ? st2[i+2] : st2[i];
        st3[i+2] = (st2[i] > st2[i+2]) ? st2[i] : st2[i+2];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if ((i & 1) == 0) begin
        st4[i]   = (st3[i] > st3[i+1]) ? st3[i+1] : st3[i];
        st4[i+1] = (st3[i] > st3[i+1]) ? st3[i] : st3[i+1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < H / 2; k++) begin
      lo[k] = {st4[2*k+1], st4[2*k]};
      hi[k] = {st4[H+2*k+1], st4[H+2*k]};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bmsv_merge8.sv -----
// bmsv_merge8: merge network over eight signed 64-bit lanes
// one lane to each word; uses bmsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module bmsv_merge8 (
  input  var bmsv_pkg::vec_t a,
  input  var bmsv_pkg::vec_t b,
  output bmsv_pkg::vec_t     lo,
  output bmsv_pkg::vec_t     hi
);

  localparam int unsigned N = 2 * bmsv_pkg::WORDS;
  localparam int unsigned H = N / 2;

  bmsv_pkg::wlane_t st0 [N];
  bmsv_pkg::wlane_t st1 [N];
  bmsv_pkg::wlane_t st2 [N];
  bmsv_pkg::wlane_t st3 [N];

  always_comb begin
    for (int k = 0; k < H; k++) begin
      st0[k]     = a[k];
      st0[N-1-k] = b[k];
    end
  end

  always_comb begin
    for (int i = 0; i < H; i++) begin
      st1[i]   = (st0[i] > st0[i+H]) ? st0[i+H] : st0[i];
      st1[i+H] = (st0[i] > st0[i+H]) ? st0[i] : st0[i+H];
    end
  end

  // half-cleaners at distance 2 and 1
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if ((i & 2) == 0) begin
        st2[i]   = (st1[i] > st1[i+2]) ? st1[i+2] : st1[i];
        st2[i+2] = (st1[i] > st1[i+2]) ? st1[i] : st1[i+2];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if ((i & 1) == 0) begin
        st3[i]   = (st2[i] > st2[i+1]) ? st2[i+1] : st2[i];
        st3[i+1] = (st2[i] > st2[i+1]) ? st2[i] : st2[i+1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < H; k++) begin
      lo[k] = st3[k];
      hi[k] = st3[H+k];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bitonic_merge_two_sorted_vectors.sv -----
// bitonic_merge_two_sorted_vectors: merges two ascending vectors in one pass
// path: an accepted word is held in the input register, then in the result register that drives out_valid
// throughput: one word per cycle while out_ready stays high; the network settles between the two registers
// reset (rst_n low, synchronous) clears both valid flags; payload is not reset
// uses bmsv_pkg, bmsv_merge16, bmsv_merge8
`timescale 1ns / 1ps
`default_nettype none

module bitonic_merge_two_sorted_vectors (
  input  var logic                 clk,
  input  var logic                 rst_n,
  input  var logic                 in_valid,
  output logic                     in_ready,
  input  var logic                 in_mode,
  input  var bmsv_pkg::word_t      in_a_word0,
  input  var bmsv_pkg::word_t      in_a_word1,
  input  var bmsv_pkg::word_t      in_a_word2,
  input  var bmsv_pkg::word_t      in_a_word3,
  input  var bmsv_pkg::word_t      in_b_word0,
  input  var bmsv_pkg::word_t      in_b_word1,
  input  var bmsv_pkg::word_t      in_b_word2,
  input  var bmsv_pkg::word_t      in_b_word3,
  output logic                     out_valid,
  input  var logic                 out_ready,
  output bmsv_pkg::word_t          out_low_word0,
  output bmsv_pkg::word_t          out_low_word1,
  output bmsv_pkg::word_t          out_low_word2,
  output bmsv_pkg::word_t          out_low_word3,
  output bmsv_pkg::word_t          out_high_word0,
  output bmsv_pkg::word_t          out_high_word1,
  output bmsv_pkg::word_t          out_high_word2,
  output bmsv_pkg::word_t          out_high_word3
);

  logic               s1_vld_r;
  bmsv_pkg::mode_t    mode_r;
  bmsv_pkg::vec_t     a_r;
  bmsv_pkg::vec_t     b_r;
  logic               o_vld_r;
  bmsv_pkg::vec_t     lo_r;
  bmsv_pkg::vec_t     hi_r;
  bmsv_pkg::vec_t     lo_nxt;
  bmsv_pkg::vec_t     hi_nxt;
  bmsv_pkg::vec_t     n_lo;
  bmsv_pkg::vec_t     n_hi;
  bmsv_pkg::vec_t     w_lo;
  bmsv_pkg::vec_t     w_hi;
  logic               adv;
  logic               in_acc;

  // input register moves on when the result register is empty or draining
  assign adv      = s1_vld_r && (!o_vld_r || out_ready);
  assign in_ready = !s1_vld_r || adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= bmsv_pkg::mode_t'(in_mode);
      a_r    <= {in_a_word3, in_a_word2, in_a_word1, in_a_word0};
      b_r    <= {in_b_word3, in_b_word2, in_b_word1, in_b_word0};
    end
  end

  bmsv_merge16 u_narrow (
    .a  (a_r),
    .b  (b_r),
    .lo (n_lo),
    .hi (n_hi)
  );

  bmsv_merge8 u_wide (
    .a  (a_r),
    .b  (b_r),
    .lo (w_lo),
    .hi (w_hi)
  );

  always_comb begin
    unique case (mode_r)
      bmsv_pkg::MODE_WIDE: begin
        lo_nxt = w_lo;
        hi_nxt = w_hi;
      end
      default: begin
        lo_nxt = n_lo;
        hi_nxt = n_hi;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= 1'b1;
    end else if (out_ready) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign out_valid      = o_vld_r;
  assign out_low_word0  = lo_r[0];
  assign out_low_word1  = lo_r[1];
  assign out_low_word2  = lo_r[2];
  assign out_low_word3  = lo_r[3];
  assign out_high_word0 = hi_r[0];
  assign out_high_word1 = hi_r[1];
  assign out_high_word2 = hi_r[2];
  assign out_high_word3 = hi_r[3];

  // an accepted word lands in the input register
  a_acc_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted word lost at input register");

  // a stalled input register keeps its word
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && o_vld_r && !out_ready) |=> (s1_vld_r && $stable(a_r) && $stable(b_r)))
    else $error("input register changed while stalled");

  // a word moved forward shows up at the output
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("advanced word missing at output");

  // a pending result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && !out_ready) |=> (o_vld_r && $stable(lo_r) && $stable(hi_r)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
